FILE: rtl/rmq_pkg.sv
// rmq_pkg: constants, types and helpers of the rotation matrix to quaternion block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    localparam int Q_W       = 16;               // q2.14 word
    localparam int Q_ONE     = 16384;            // 1.0 in q2.14
    localparam int Q_MAX     = 32767;
    localparam int Q_MIN_MAG = 32768;
    localparam int LANES     = 3;                // divided components
    localparam int AXES      = 4;                // w, x, y, z

    localparam int RAD_W     = 17;               // radicand, 1 .. 114687
    localparam int RAD_SHIFT = 30;
    localparam int SQ_XW     = 48;               // radicand << 30, padded to even
    localparam int ROOT_W    = SQ_XW / 2;        // 24-bit root
    localparam int SQ_STEPS  = ROOT_W;           // one root bit per stage
    localparam int SQ_RW     = ROOT_W + 3;       // partial remainder

    localparam int MAG_W     = 17;               // magnitude of a difference or sum
    localparam int DIV_SHIFT = 21;
    localparam int DIV_NW    = MAG_W + DIV_SHIFT;  // 38-bit dividend
    localparam int DIV_STEPS = 23;               // quotient bits
    localparam int DIV_HI    = DIV_NW - DIV_STEPS; // bits known to be below the divisor
    localparam int DIV_RW    = ROOT_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int BIG_SHIFT = 9;
    localparam int BIG_RND   = 256;

    typedef logic [RAD_W-1:0]     rad_t;
    typedef logic [ROOT_W-1:0]    root_t;
    typedef logic [MAG_W-1:0]     mag_t;
    typedef logic [DIV_STEPS-1:0] quo_t;
    typedef logic [1:0]           axis_t;

    // carried alongside the square root
    typedef struct packed {
        axis_t                  big_pos;
        logic [LANES-1:0]       neg;
        logic                   degenerate;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } side_a_t;

    // carried alongside the dividers
    typedef struct packed {
        axis_t            big_pos;
        logic [LANES-1:0] neg;
        logic             degenerate;
        logic [Q_W-1:0]   big;
    } side_b_t;

    // signed saturation of a rounded quotient magnitude
    function automatic logic [Q_W-1:0] sat_q(input quo_t q, input logic neg);
        logic [Q_W-1:0] r;
        if (neg)
        begin
            if (q > DIV_STEPS'(Q_MIN_MAG))
                r = Q_W'(Q_MIN_MAG);
            else
                r = Q_W'(~q[Q_W-1:0] + 1'b1);
        end
        else
        begin
            if (q > DIV_STEPS'(Q_MAX))
                r = Q_W'(Q_MAX);
            else
                r = q[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rmq_in_if.sv
// rmq_in_if: input channel carrying one 3x3 matrix in q2.14
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rmq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/rmq_out_if.sv
// rmq_out_if: output channel carrying one quaternion in q2.14 and a flag
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rmq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               degenerate;

    modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
    modport sink   (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion, q2.14
// depends on rmq_pkg, rmq_in_if, rmq_out_if, rmq_isqrt, rmq_div
//
// usage
//   in_ch  : one transaction carries the nine matrix entries r00 .. r22 (q2.14)
//   out_ch : one transaction carries qw, qx, qy, qz (q2.14, saturated) and the
//            degenerate flag, raised when the square root radicand was not positive
//   every input transaction yields exactly one output transaction, in order
//   pipeline: input register, 24 root stages, 24 divider stages, output register
//   throughput: one matrix per cycle while out_ch is not stalled; the pipeline
//               holds up to 50 in flight
//   stall: the whole pipeline advances together; while out_ch.valid is high and
//          out_ch.ready low nothing moves and in_ch.ready is low, so no
//          transaction is lost or repeated
//   reset: rst_n clears every valid bit at once; the datapath holds no state
//          that matters and no clearing pass is needed
//   one square root pipeline finds the large component, three dividers in
//   parallel find the other three from the off-diagonal terms
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmq_in_if.sink     in_ch,
    rmq_out_if.source  out_ch
);

    // global advance: the output register is free or is being drained
    logic adv;

    // ---------------------------------------------------------------
    // input decode: trace test, largest diagonal, radicand, numerators
    // ---------------------------------------------------------------
    logic signed [15:0] m [3][3];
    logic signed [17:0] trace;
    logic               tpos;
    rmq_pkg::axis_t     idx;
    rmq_pkg::axis_t     jdx;
    rmq_pkg::axis_t     kdx;
    logic signed [18:0] rad_full;
    logic               degen;
    rmq_pkg::rad_t      rad_in;
    logic signed [16:0] num [rmq_pkg::AXES];
    rmq_pkg::side_a_t   side_in;

    always_comb
    begin
        m[0][0] = in_ch.r00;
        m[0][1] = in_ch.r01;
        m[0][2] = in_ch.r02;
        m[1][0] = in_ch.r10;
        m[1][1] = in_ch.r11;
        m[1][2] = in_ch.r12;
        m[2][0] = in_ch.r20;
        m[2][1] = in_ch.r21;
        m[2][2] = in_ch.r22;

        trace = 18'(m[0][0]) + 18'(m[1][1]) + 18'(m[2][2]);
        tpos  = (trace > 18'sd0);

        // largest diagonal, ties keep the lower index
        idx = 2'd0;
        if (m[1][1] > m[0][0])
            idx = 2'd1;
        if (m[2][2] > m[idx][idx])
            idx = 2'd2;
        case (idx)
            2'd0:    begin jdx = 2'd1; kdx = 2'd2; end
            2'd1:    begin jdx = 2'd2; kdx = 2'd0; end
            default: begin jdx = 2'd0; kdx = 2'd1; end
        endcase

        if (tpos)
            rad_full = 19'(trace) + 19'(rmq_pkg::Q_ONE);
        else
            rad_full = 19'(m[idx][idx]) - 19'(m[jdx][jdx]) - 19'(m[kdx][kdx])
                     + 19'(rmq_pkg::Q_ONE);

        // not a rotation: clamp the radicand to one lsb
        degen  = !tpos && (rad_full <= 19'sd0);
        rad_in = degen ? rmq_pkg::RAD_W'(1) : rad_full[rmq_pkg::RAD_W-1:0];

        // numerator for every axis, the large one left at zero
        num[0] = '0;
        num[1] = '0;
        num[2] = '0;
        num[3] = '0;
        if (tpos)
        begin
            num[1] = 17'(m[2][1]) - 17'(m[1][2]);
            num[2] = 17'(m[0][2]) - 17'(m[2][0]);
            num[3] = 17'(m[1][0]) - 17'(m[0][1]);
        end
        else
        begin
            case (idx)
                2'd0:
                begin
                    num[0] = 17'(m[2][1]) - 17'(m[1][2]);
                    num[2] = 17'(m[1][0]) + 17'(m[0][1]);
                    num[3] = 17'(m[2][0]) + 17'(m[0][2]);
                end
                2'd1:
                begin
                    num[0] = 17'(m[0][2]) - 17'(m[2][0]);
                    num[3] = 17'(m[2][1]) + 17'(m[1][2]);
                    num[1] = 17'(m[0][1]) + 17'(m[1][0]);
                end
                default:
                begin
                    num[0] = 17'(m[1][0]) - 17'(m[0][1]);
                    num[1] = 17'(m[0][2]) + 17'(m[2][0]);
                    num[2] = 17'(m[1][2]) + 17'(m[2][1]);
                end
            endcase
        end

        side_in.big_pos    = tpos ? 2'd0 : idx + 2'd1;
        side_in.degenerate = degen;
        // lanes take the three other axes in ascending order
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            logic signed [16:0] v;
            rmq_pkg::axis_t     lp;
            lp = (2'(l) < side_in.big_pos) ? 2'(l) : 2'(l + 1);
            v  = num[lp];
            side_in.neg[l] = v[16];
            side_in.mag[l] = v[16] ? rmq_pkg::MAG_W'(-v) : rmq_pkg::MAG_W'(v);
        end
    end

    // input register stage
    logic             i_valid_reg;
    rmq_pkg::rad_t    rad_reg;
    rmq_pkg::side_a_t side_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_valid_reg <= 1'b0;
        else if (adv)
            i_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg    <= rad_in;
            side_i_reg <= side_in;
        end
    end

    // ---------------------------------------------------------------
    // square root: twice the large component in q.22
    // ---------------------------------------------------------------
    rmq_pkg::root_t root;

    rmq_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    logic             sa_valid_reg [rmq_pkg::SQ_STEPS];
    rmq_pkg::side_a_t sa_reg       [rmq_pkg::SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < rmq_pkg::SQ_STEPS; s++)
                sa_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg[0] <= i_valid_reg;
            for (int s = 1; s < rmq_pkg::SQ_STEPS; s++)
                sa_valid_reg[s] <= sa_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg[0] <= side_i_reg;
            for (int s = 1; s < rmq_pkg::SQ_STEPS; s++)
                sa_reg[s] <= sa_reg[s-1];
        end
    end

    // large component, rounded half up
    logic [rmq_pkg::ROOT_W:0] big_sum;
    rmq_pkg::side_a_t         sa_last;
    rmq_pkg::side_b_t         side_b_in;

    always_comb
    begin
        sa_last  = sa_reg[rmq_pkg::SQ_STEPS-1];
        big_sum  = {1'b0, root} + (rmq_pkg::ROOT_W + 1)'(rmq_pkg::BIG_RND);
        side_b_in.big_pos    = sa_last.big_pos;
        side_b_in.neg        = sa_last.neg;
        side_b_in.degenerate = sa_last.degenerate;
        side_b_in.big        = big_sum[rmq_pkg::BIG_SHIFT +: rmq_pkg::Q_W];
    end

    // ---------------------------------------------------------------
    // three dividers for the off-diagonal components
    // ---------------------------------------------------------------
    rmq_pkg::quo_t quo [rmq_pkg::LANES];

    for (genvar l = 0; l < rmq_pkg::LANES; l++)
    begin : g_lane
        rmq_div u_div (
            .clk  (clk),
            .en   (adv),
            .mag  (sa_last.mag[l]),
            .root (root),
            .quo  (quo[l])
        );
    end

    logic             sb_valid_reg [rmq_pkg::DIV_LAT];
    rmq_pkg::side_b_t sb_reg       [rmq_pkg::DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < rmq_pkg::DIV_LAT; s++)
                sb_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            sb_valid_reg[0] <= sa_valid_reg[rmq_pkg::SQ_STEPS-1];
            for (int s = 1; s < rmq_pkg::DIV_LAT; s++)
                sb_valid_reg[s] <= sb_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= side_b_in;
            for (int s = 1; s < rmq_pkg::DIV_LAT; s++)
                sb_reg[s] <= sb_reg[s-1];
        end
    end

    // ---------------------------------------------------------------
    // reassembly, saturation and output register
    // ---------------------------------------------------------------
    rmq_pkg::side_b_t                        sb_last;
    logic [rmq_pkg::AXES-1:0][rmq_pkg::Q_W-1:0] q_next;

    always_comb
    begin
        sb_last = sb_reg[rmq_pkg::DIV_LAT-1];
        for (int p = 0; p < rmq_pkg::AXES; p++)
        begin
            rmq_pkg::axis_t ln;
            ln = (2'(p) < sb_last.big_pos) ? 2'(p) : 2'(p - 1);
            if (2'(p) == sb_last.big_pos)
                q_next[p] = (sb_last.big > rmq_pkg::Q_W'(rmq_pkg::Q_MAX))
                          ? rmq_pkg::Q_W'(rmq_pkg::Q_MAX) : sb_last.big;
            else
                q_next[p] = rmq_pkg::sat_q(quo[ln], sb_last.neg[ln]);
        end
    end

    logic                                    out_valid_reg;
    logic [rmq_pkg::AXES-1:0][rmq_pkg::Q_W-1:0] q_reg;
    logic                                    degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sb_valid_reg[rmq_pkg::DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg     <= q_next;
            degen_reg <= sb_last.degenerate;
        end
    end

    assign adv               = !out_valid_reg || out_ch.ready;
    assign in_ch.ready       = adv;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.qw         = q_reg[0];
    assign out_ch.qx         = q_reg[1];
    assign out_ch.qy         = q_reg[2];
    assign out_ch.qz         = q_reg[3];
    assign out_ch.degenerate = degen_reg;

endmodule

`default_nettype wire

FILE: rtl/rmq_isqrt.sv
// rmq_isqrt: pipelined integer square root of rad << 30, one root bit per stage
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_isqrt (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire rmq_pkg::rad_t rad,
    output rmq_pkg::root_t     root
);

    logic [rmq_pkg::SQ_XW-1:0]  x_reg    [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_XW-1:0]  x_next   [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_RW-1:0]  rem_reg  [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_RW-1:0]  rem_next [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::ROOT_W-1:0] root_reg [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::ROOT_W-1:0] root_next[rmq_pkg::SQ_STEPS];

    always_comb
    begin
        logic [rmq_pkg::SQ_XW-1:0]  xi;
        logic [rmq_pkg::SQ_RW-1:0]  ri;
        logic [rmq_pkg::ROOT_W-1:0] qi;
        logic [rmq_pkg::SQ_RW-1:0]  r2;
        logic [rmq_pkg::SQ_RW-1:0]  trial;
        for (int s = 0; s < rmq_pkg::SQ_STEPS; s++)
        begin
            if (s == 0)
            begin
                xi = {{(rmq_pkg::SQ_XW - rmq_pkg::RAD_W - rmq_pkg::RAD_SHIFT){1'b0}},
                      rad, {rmq_pkg::RAD_SHIFT{1'b0}}};
                ri = '0;
                qi = '0;
            end
            else
            begin
                xi = x_reg[s-1];
                ri = rem_reg[s-1];
                qi = root_reg[s-1];
            end
            // bring down the next two radicand bits
            r2    = {ri[rmq_pkg::SQ_RW-3:0], xi[rmq_pkg::SQ_XW-1 -: 2]};
            trial = {{(rmq_pkg::SQ_RW - rmq_pkg::ROOT_W - 2){1'b0}}, qi, 2'b01};
            if (r2 >= trial)
            begin
                rem_next[s]  = r2 - trial;
                root_next[s] = {qi[rmq_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = r2;
                root_next[s] = {qi[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
            x_next[s] = {xi[rmq_pkg::SQ_XW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < rmq_pkg::SQ_STEPS; s++)
            begin
                x_reg[s]    <= x_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root = root_reg[rmq_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/rmq_div.sv
// rmq_div: pipelined rounded division (mag << 21 + root / 2) / root, one bit per stage
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_div (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire rmq_pkg::mag_t  mag,
    input  wire rmq_pkg::root_t root,
    output rmq_pkg::quo_t       quo
);

    logic [rmq_pkg::DIV_NW-1:0]    n_pre_reg;
    logic [rmq_pkg::ROOT_W-1:0]    d_pre_reg;

    logic [rmq_pkg::DIV_STEPS-1:0] n_reg   [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_STEPS-1:0] n_next  [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_RW-1:0]    rem_reg [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_RW-1:0]    rem_next[rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_STEPS-1:0] q_reg   [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_STEPS-1:0] q_next  [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]    d_reg   [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]    d_next  [rmq_pkg::DIV_STEPS];

    always_comb
    begin
        logic [rmq_pkg::DIV_STEPS-1:0] ni;
        logic [rmq_pkg::DIV_RW-1:0]    ri;
        logic [rmq_pkg::DIV_STEPS-1:0] qi;
        logic [rmq_pkg::ROOT_W-1:0]    di;
        logic [rmq_pkg::DIV_RW:0]      r2;
        for (int s = 0; s < rmq_pkg::DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                // top bits of the dividend are always below the divisor (root >= 2^15)
                ni = n_pre_reg[rmq_pkg::DIV_STEPS-1:0];
                ri = {{(rmq_pkg::DIV_RW - rmq_pkg::DIV_HI){1'b0}},
                      n_pre_reg[rmq_pkg::DIV_NW-1 -: rmq_pkg::DIV_HI]};
                qi = '0;
                di = d_pre_reg;
            end
            else
            begin
                ni = n_reg[s-1];
                ri = rem_reg[s-1];
                qi = q_reg[s-1];
                di = d_reg[s-1];
            end
            r2 = {ri, ni[rmq_pkg::DIV_STEPS-1]};
            if (r2 >= {1'b0, di})
            begin
                rem_next[s] = rmq_pkg::DIV_RW'(r2 - {1'b0, di});
                q_next[s]   = {qi[rmq_pkg::DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = r2[rmq_pkg::DIV_RW-1:0];
                q_next[s]   = {qi[rmq_pkg::DIV_STEPS-2:0], 1'b0};
            end
            n_next[s] = {ni[rmq_pkg::DIV_STEPS-2:0], 1'b0};
            d_next[s] = di;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // dividend with half the divisor added for rounding
            n_pre_reg <= {mag, {rmq_pkg::DIV_SHIFT{1'b0}}}
                       + {{(rmq_pkg::DIV_NW - rmq_pkg::ROOT_W + 1){1'b0}},
                          root[rmq_pkg::ROOT_W-1:1]};
            d_pre_reg <= root;
            for (int s = 0; s < rmq_pkg::DIV_STEPS; s++)
            begin
                n_reg[s]   <= n_next[s];
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                d_reg[s]   <= d_next[s];
            end
        end
    end

    assign quo = q_reg[rmq_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/rmq_checker.sv
// rmq_port_checker: port-level assertions for rotation_matrix_to_quaternion, with its bind
// depends on rotation_matrix_to_quaternion
`timescale 1ns / 1ps
`default_nettype none

module rmq_port_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] qw,
    input wire logic signed [15:0] qx,
    input wire logic signed [15:0] qy,
    input wire logic signed [15:0] qz,
    input wire logic               degenerate
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(qw) && $stable(qx) && $stable(qy) && $stable(qz)
            && $stable(degenerate))
        else $error("result changed while stalled");

    // the pipeline takes a matrix exactly when it can move
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output stall");

    // at least one component, such as the large one, is always positive
    a_big_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (qw > 16'sd0 || qx > 16'sd0 || qy > 16'sd0 || qz > 16'sd0))
        else $error("no positive component in result");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_port_checker u_rmq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .qw         (out_ch.qw),
    .qx         (out_ch.qx),
    .qy         (out_ch.qy),
    .qz         (out_ch.qz),
    .degenerate (out_ch.degenerate)
);

`default_nettype wire
